// ===== src/gbw_pkg.sv =====
package gbw_pkg;

  localparam int EXP_BITS = 21;
  localparam int G_W      = 31;
  localparam int E_W      = 30;

  localparam logic [G_W-1:0] G_ONE       = 31'h4000_0000;
  localparam logic [60:0]    EXP_ROUND   = 61'h2000_0000;
  localparam logic [16:0]    WEIGHT_ONE  = 17'h1_0000;

  function automatic logic [E_W-1:0] q30_from_dec(input logic [63:0] d);
    return E_W'((d * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
  endfunction

  // exp(-2^(j-16)) in q0.30
  localparam logic [E_W-1:0] EXP_COEF [EXP_BITS] = '{
    q30_from_dec(64'd999984741), q30_from_dec(64'd999969483),
    q30_from_dec(64'd999938967), q30_from_dec(64'd999877937),
    q30_from_dec(64'd999755889), q30_from_dec(64'd999511838),
    q30_from_dec(64'd999023914), q30_from_dec(64'd998048781),
    q30_from_dec(64'd996101369), q30_from_dec(64'd992217938),
    q30_from_dec(64'd984496437), q30_from_dec(64'd969233234),
    q30_from_dec(64'd939413063), q30_from_dec(64'd882496903),
    q30_from_dec(64'd778800783), q30_from_dec(64'd606530660),
    q30_from_dec(64'd367879441), q30_from_dec(64'd135335283),
    q30_from_dec(64'd18315639),  q30_from_dec(64'd335463),
    q30_from_dec(64'd113)
  };

endpackage

// ===== src/gaussian_blur_weight_generator_core.sv =====
// throughput: one item per cycle while the output is not stalled; 21-stage exponent
//   divider, 21-stage exp multiplier chain and 17-stage normalizing divider, one bit per stage
// a stalled output holds the whole pipeline
// reset: synchronous, active high, clears all valid bits; no clearing pass
module gaussian_blur_weight_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        sigma_valid,
  output logic        sigma_stall,
  input  logic [15:0] sigma,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [16:0] weight_center,
  output logic [16:0] weight_near,
  output logic [16:0] weight_far,
  output logic [15:0] offset_near,
  output logic [15:0] offset_far,
  output logic        bad_sigma
);

  localparam int GW = gbw_pkg::G_W;
  localparam int NB = gbw_pkg::EXP_BITS;

  logic adv;

  logic        a_valid;
  logic [15:0] a_sigma;
  logic [31:0] a_den;

  logic        b_valid;
  logic        b_bad;
  logic [31:0] b_den;

  logic [3:0][43:0]   xnum, xnum_in;
  logic [3:0][31:0]   xden;
  logic [3:0]         ovf;
  logic               d1_valid;
  logic [3:0][NB-1:0] x_q;
  logic [4:0]         d1_side;

  logic               e_valid;
  logic [3:0][GW-1:0] g_m, g;
  logic [4:0]         e_side;

  logic        c_valid, c_bad;
  logic [31:0] c_near, c_far, c_pn;
  logic [32:0] c_pf;
  logic [33:0] c_sum;

  logic             d_valid;
  logic [4:0][46:0] d_num;
  logic [4:0][33:0] d_den;
  logic [2:0]       d_side;

  logic             q_valid;
  logic [4:0][16:0] q2;
  logic [2:0]       q_side;

  assign adv         = !(result_valid && result_stall);
  assign sigma_stall = !adv;

  // square of sigma
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= sigma_valid;
      b_valid <= a_valid;
      c_valid <= e_valid;
      d_valid <= c_valid;
    end
  end

  assign a_den = 32'(a_sigma) * 32'(a_sigma);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sigma <= sigma;
      b_den   <= a_den;
      b_bad   <= (a_sigma == 16'd0);
    end
  end

  // exponent numerators, saturate when the quotient reaches 2^21
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xnum[i]    = (44'((i + 1) * (i + 1)) << 39) | 44'(b_den >> 1);
      ovf[i]     = 32'(xnum[i][43:21]) >= b_den;
      xnum_in[i] = ovf[i] ? 44'd0 : xnum[i];
      xden[i]    = b_den;
    end
  end

  gbw_div #(
    .LANES (4),
    .NUM_W (44),
    .DEN_W (32),
    .Q_W   (NB),
    .SIDE_W(5)
  ) u_xdiv (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (b_valid),
    .num      (xnum_in),
    .den      (xden),
    .side_in  ({b_bad, ovf}),
    .out_valid(d1_valid),
    .quo      (x_q),
    .side_out (d1_side)
  );

  gbw_exp #(
    .LANES (4),
    .SIDE_W(5)
  ) u_exp (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (d1_valid),
    .x        (x_q),
    .side_in  (d1_side),
    .out_valid(e_valid),
    .g        (g_m),
    .side_out (e_side)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      g[i] = e_side[i] ? '0 : g_m[i];
    end
  end

  // pair sums and normalizer
  always_ff @(posedge clk) begin
    if (adv) begin
      c_bad  <= e_side[4];
      c_near <= 32'(g[0]) + 32'(g[1]);
      c_far  <= 32'(g[2]) + 32'(g[3]);
      c_pn   <= 32'(g[0]) + (32'(g[1]) << 1);
      c_pf   <= 33'(g[2]) + (33'(g[2]) << 1) + (33'(g[3]) << 2);
      c_sum  <= 34'(gbw_pkg::G_ONE)
              + ((34'(g[0]) + 34'(g[1]) + 34'(g[2]) + 34'(g[3])) << 1);
    end
  end

  // rounded numerators for the output divisions
  always_ff @(posedge clk) begin
    if (adv) begin
      d_num[0] <= (47'(gbw_pkg::G_ONE) << 16) + 47'(c_sum >> 1);
      d_num[1] <= (47'(c_near) << 16) + 47'(c_sum >> 1);
      d_num[2] <= (47'(c_far) << 16) + 47'(c_sum >> 1);
      d_num[3] <= (47'(c_pn) << 13) + 47'(c_near >> 1);
      d_num[4] <= (47'(c_pf) << 13) + 47'(c_far >> 1);
      d_den[0] <= c_sum;
      d_den[1] <= c_sum;
      d_den[2] <= c_sum;
      d_den[3] <= 34'(c_near);
      d_den[4] <= 34'(c_far);
      d_side   <= {c_bad, c_near == 32'd0, c_far == 32'd0};
    end
  end

  gbw_div #(
    .LANES (5),
    .NUM_W (47),
    .DEN_W (34),
    .Q_W   (17),
    .SIDE_W(3)
  ) u_ndiv (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (d_valid),
    .num      (d_num),
    .den      (d_den),
    .side_in  (d_side),
    .out_valid(q_valid),
    .quo      (q2),
    .side_out (q_side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_sigma     <= q_side[2];
      weight_center <= q_side[2] ? gbw_pkg::WEIGHT_ONE : q2[0];
      weight_near   <= q_side[2] ? 17'd0 : q2[1];
      weight_far    <= q_side[2] ? 17'd0 : q2[2];
      offset_near   <= (q_side[2] || q_side[1]) ? 16'd0 : q2[3][15:0];
      offset_far    <= (q_side[2] || q_side[0]) ? 16'd0 : q2[4][15:0];
    end
  end

`ifndef SYNTH
  a_bad_subst: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_sigma |-> weight_center == gbw_pkg::WEIGHT_ONE
      && weight_near == 17'd0 && weight_far == 17'd0
      && offset_near == 16'd0 && offset_far == 16'd0)
    else $error("substituted item for zero sigma is wrong");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> sigma_stall)
    else $error("input taken while output is held");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    result_valid && !bad_sigma |->
      (19'(weight_center) + (19'(weight_near) << 1) + (19'(weight_far) << 1)) >= 19'd65533
      && (19'(weight_center) + (19'(weight_near) << 1) + (19'(weight_far) << 1))
        <= 19'd65539)
    else $error("weights do not sum to one");

  a_near_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !bad_sigma && weight_near != 17'd0 |->
      offset_near >= 16'd8192 && offset_near <= 16'd16384)
    else $error("near offset out of range");
`endif

endmodule

// ===== src/gbw_div.sv =====
module gbw_div #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 4,
  parameter int Q_W    = 4,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]       num,
  input  logic [LANES-1:0][DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic [LANES-1:0][Q_W-1:0]         quo,
  output logic [SIDE_W-1:0]                 side_out
);

  logic [LANES-1:0][DEN_W-1:0] rem_r  [Q_W];
  logic [LANES-1:0][DEN_W-1:0] den_r  [Q_W];
  logic [LANES-1:0][Q_W-1:0]   low_r  [Q_W];
  logic [LANES-1:0][Q_W-1:0]   quo_r  [Q_W];
  logic [SIDE_W-1:0]           side_r [Q_W];
  logic [Q_W-1:0]              vld;

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] rem_i, den_i, rem_n;
    logic [LANES-1:0][Q_W-1:0]   low_i, quo_i, low_n, quo_n;
    logic [LANES-1:0][DEN_W:0]   trial;
    logic [LANES-1:0]            ge;
    logic [SIDE_W-1:0]           side_i;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = DEN_W'(num[l] >> Q_W);
          low_i[l] = num[l][Q_W-1:0];
          quo_i[l] = '0;
        end
      end
      assign den_i  = den;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign low_i  = low_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_i[l], low_i[l][Q_W-1]};
        ge[l]    = trial[l] >= {1'b0, den_i[l]};
        rem_n[l] = ge[l] ? DEN_W'(trial[l] - {1'b0, den_i[l]}) : trial[l][DEN_W-1:0];
        low_n[l] = {low_i[l][Q_W-2:0], 1'b0};
        quo_n[l] = {quo_i[l][Q_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_n;
        den_r[k]  <= den_i;
        low_r[k]  <= low_n;
        quo_r[k]  <= quo_n;
        side_r[k] <= side_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Q_W-2:0], in_valid};
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quo       = quo_r[Q_W-1];
  assign side_out  = side_r[Q_W-1];

endmodule

// ===== src/gbw_exp.sv =====
module gbw_exp #(
  parameter int LANES  = 4,
  parameter int SIDE_W = 1
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          adv,
  input  logic                                          in_valid,
  input  logic [LANES-1:0][gbw_pkg::EXP_BITS-1:0]       x,
  input  logic [SIDE_W-1:0]                             side_in,
  output logic                                          out_valid,
  output logic [LANES-1:0][gbw_pkg::G_W-1:0]            g,
  output logic [SIDE_W-1:0]                             side_out
);

  localparam int NB = gbw_pkg::EXP_BITS;
  localparam int GW = gbw_pkg::G_W;

  logic [LANES-1:0][GW-1:0] m_r    [NB];
  logic [LANES-1:0][NB-1:0] x_r    [NB];
  logic [SIDE_W-1:0]        side_r [NB];
  logic [NB-1:0]            vld;

  // stage j applies the factor for exponent bit j
  for (genvar j = 0; j < NB; j++) begin : g_stage
    logic [LANES-1:0][GW-1:0] m_i, m_n;
    logic [LANES-1:0][NB-1:0] x_i;
    logic [LANES-1:0][60:0]   prod, rnd;
    logic [SIDE_W-1:0]        side_i;

    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          m_i[l] = gbw_pkg::G_ONE;
        end
      end
      assign x_i    = x;
      assign side_i = side_in;
    end else begin : g_next
      assign m_i    = m_r[j-1];
      assign x_i    = x_r[j-1];
      assign side_i = side_r[j-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        prod[l] = 61'(m_i[l]) * 61'(gbw_pkg::EXP_COEF[j]);
        rnd[l]  = prod[l] + gbw_pkg::EXP_ROUND;
        m_n[l]  = x_i[l][j] ? rnd[l][60:30] : m_i[l];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[j]    <= m_n;
        x_r[j]    <= x_i;
        side_r[j] <= side_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NB-2:0], in_valid};
    end
  end

  assign out_valid = vld[NB-1];
  assign g         = m_r[NB-1];
  assign side_out  = side_r[NB-1];

endmodule

// ===== test/gaussian_blur_weight_generator_core_test.sv =====
`timescale 1ns / 100ps

module gaussian_blur_weight_generator_core_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int DIRECTED_ROWS  = 18;
  localparam int PEND_DEPTH     = 4096;

  typedef struct packed {
    logic [16:0] weight_center;
    logic [16:0] weight_near;
    logic [16:0] weight_far;
    logic [15:0] offset_near;
    logic [15:0] offset_far;
    logic        bad_sigma;
  } blur_weights_t;

  typedef struct {
    logic [15:0] sigma;
    bit          known;
    blur_weights_t weights;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sigma_valid = 1'b0;
  logic        sigma_stall;
  logic [15:0] sigma = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [16:0] weight_center;
  logic [16:0] weight_near;
  logic [16:0] weight_far;
  logic [15:0] offset_near;
  logic [15:0] offset_far;
  logic        bad_sigma;

  blur_weights_t pending_weights [PEND_DEPTH];
  int  pend_wr = 0;
  int  pend_rd = 0;
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  timed_out = 1'b0;
  bit  running = 1'b1;
  logic [63:0] exp_coef_q30 [gbw_pkg::EXP_BITS];

  gaussian_blur_weight_generator_core dut (
    .clk(clk), .rst(rst),
    .sigma_valid(sigma_valid), .sigma_stall(sigma_stall), .sigma(sigma),
    .result_valid(result_valid), .result_stall(result_stall),
    .weight_center(weight_center), .weight_near(weight_near),
    .weight_far(weight_far), .offset_near(offset_near),
    .offset_far(offset_far), .bad_sigma(bad_sigma)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    exp_coef_q30 = '{
      64'd999984741, 64'd999969483, 64'd999938967, 64'd999877937,
      64'd999755889, 64'd999511838, 64'd999023914, 64'd998048781,
      64'd996101369, 64'd992217938, 64'd984496437, 64'd969233234,
      64'd939413063, 64'd882496903, 64'd778800783, 64'd606530660,
      64'd367879441, 64'd135335283, 64'd18315639,  64'd335463,
      64'd113};
    foreach (exp_coef_q30[j])
      exp_coef_q30[j] = (exp_coef_q30[j] * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  end

  function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  function automatic logic [63:0] gauss_q30(logic [63:0] x);
    logic [63:0] m;
    m = 64'd1 << 30;
    if (x >= (64'd1 << gbw_pkg::EXP_BITS)) return 0;
    for (int j = 0; j < gbw_pkg::EXP_BITS; j++)
      if (x[j]) m = (m * exp_coef_q30[j] + (64'd1 << 29)) >> 30;
    return m;
  endfunction

  function automatic blur_weights_t blur_weights(logic [15:0] s);
    blur_weights_t w;
    logic [63:0] g[5];
    logic [63:0] den, near, far, total;
    w = '0;
    if (s == 0) begin
      w.weight_center = gbw_pkg::WEIGHT_ONE;
      w.bad_sigma = 1'b1;
      return w;
    end
    den = 64'(s) * 64'(s);
    for (int i = 0; i < 5; i++)
      g[i] = gauss_q30(round_div(64'(i * i) << 39, den));
    near = g[1] + g[2];
    far = g[3] + g[4];
    total = g[0] + 2 * (near + far);
    w.weight_center = 17'(round_div(g[0] << 16, total));
    w.weight_near = 17'(round_div(near << 16, total));
    w.weight_far = 17'(round_div(far << 16, total));
    w.offset_near = 16'(round_div((g[1] + 2 * g[2]) << 13, near));
    w.offset_far = 16'(round_div((3 * g[3] + 4 * g[4]) << 13, far));
    return w;
  endfunction

  task automatic send_sigma(logic [15:0] s, blur_weights_t w);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      sigma_valid <= 1'b0;
      @(posedge clk);
    end
    sigma_valid <= 1'b1;
    sigma <= s;
    pending_weights[pend_wr % PEND_DEPTH] = w;
    pend_wr++;
    @(posedge clk);
    while (sigma_stall) @(posedge clk);
  endtask

  // receiver stall and result checking
  always @(posedge clk) begin
    blur_weights_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pend_rd == pend_wr) begin
          $error("unexpected result item");
          fail_count++;
        end else begin
          want = pending_weights[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (weight_center !== want.weight_center) begin
            $error("weight_center exp %0d got %0d", want.weight_center, weight_center);
            fail_count++;
          end
          if (weight_near !== want.weight_near) begin
            $error("weight_near exp %0d got %0d", want.weight_near, weight_near);
            fail_count++;
          end
          if (weight_far !== want.weight_far) begin
            $error("weight_far exp %0d got %0d", want.weight_far, weight_far);
            fail_count++;
          end
          if (offset_near !== want.offset_near) begin
            $error("offset_near exp %0d got %0d", want.offset_near, offset_near);
            fail_count++;
          end
          if (offset_far !== want.offset_far) begin
            $error("offset_far exp %0d got %0d", want.offset_far, offset_far);
            fail_count++;
          end
          if (bad_sigma !== want.bad_sigma) begin
            $error("bad_sigma exp %0d got %0d", want.bad_sigma, bad_sigma);
            fail_count++;
          end
        end
      end
      result_stall <= stall_pct > 0 && $urandom_range(99, 0) < stall_pct;
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (sigma_valid && !sigma_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (running) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("gaussian_blur_weight_generator_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t rows [DIRECTED_ROWS];
    logic [15:0] picks [DIRECTED_ROWS];
    blur_weights_t zero_w;
    logic [15:0] s;
    int r;
    zero_w = '0;
    zero_w.weight_center = gbw_pkg::WEIGHT_ONE;
    zero_w.bad_sigma = 1'b1;
    picks = '{16'h0000, 16'h0001, 16'h0010, 16'h0100, 16'h0400, 16'h0800,
      16'h1000, 16'h1800, 16'h2000, 16'h4000, 16'h8000, 16'hFFFF, 16'hFFFE,
      16'h5555, 16'hAAAA, 16'h0C00, 16'h0200, 16'h0000};
    // zero sigma rows carry the substituted item
    foreach (picks[k]) rows[k] = '{picks[k], picks[k] == 16'h0000, zero_w};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k])
      send_sigma(rows[k].sigma, rows[k].known ? rows[k].weights : blur_weights(rows[k].sigma));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n * 4) / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      r = $urandom_range(9, 0);
      if (r < 4) s = 16'($urandom_range(16'h2000, 16'h0100));
      else if (r < 5) s = 16'($urandom_range(16'h00FF, 0));
      else s = 16'($urandom);
      send_sigma(s, blur_weights(s));
    end
    sigma_valid <= 1'b0;
    send_idle_pct = 0;

    while (pend_rd != pend_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    running = 1'b0;
    if (fail_count == 0 && pend_rd == pend_wr)
      $display("gaussian_blur_weight_generator_core regression: pass");
    else
      $display("gaussian_blur_weight_generator_core regression: fail");
    $finish;
  end

endmodule
